/* design/sips_pkg.sv */
// Shared types, constants and the ID check-bit function for the sensor ID poll scheduler.
// No dependencies; imported by sips_ctrl and sensor_id_poll_scheduler_top.
`default_nettype none

package sips_pkg;

  localparam logic [7:0]  PRIM_DATA     = 8'h10;
  localparam logic [7:0]  PRIM_NULL     = 8'h00;
  localparam logic [4:0]  ID_MASK       = 5'h1F;
  localparam int unsigned US_PER_MS     = 1000;
  localparam int unsigned PERIOD_W      = 20;
  localparam int unsigned WIN_MS_W      = 16;
  localparam int unsigned WIN_US_W      = 26;
  localparam logic [19:0] PERIOD_MIN    = 20'd1;
  localparam logic [19:0] PERIOD_MAX    = 20'd1000000;
  localparam logic [15:0] WIN_MS_MIN    = 16'd1;
  localparam logic [15:0] WIN_MS_MAX    = 16'd60000;
  localparam logic [19:0] PERIOD_RESET  = 20'd10000;
  localparam logic [15:0] WIN_MS_RESET  = 16'd5000;

  // register byte address bit 2 selects the register
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  typedef enum logic [1:0] {
    OP_POLL    = 2'd0,
    OP_REPLY   = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_EXEC,
    ST_READ,
    ST_SRCH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_us;
    logic [7:0]  rx_id_byte;
  } item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] poll_period_us;
    logic [WIN_MS_W-1:0] discovery_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0] tx_id_byte;
    logic [7:0] tx_prim;
    logic       rx_id_valid;
    logic [4:0] rx_id;
    logic [4:0] ids_found;
    logic       scanning;
  } res_t;

  // b5 = i0^i1^i2, b6 = i2^i3^i4, b7 = i0^i2^i4
  function automatic logic [7:0] add_check_bits(input logic [4:0] id);
    logic c5, c6, c7;
    c5 = id[0] ^ id[1] ^ id[2];
    c6 = id[2] ^ id[3] ^ id[4];
    c7 = id[0] ^ id[2] ^ id[4];
    return {c7, c6, c5, id};
  endfunction

endpackage

`default_nettype wire

/* design/sips_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module sips_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/sips_ctrl.sv */
// Poll/reply/restart sequencer: scheduler state registers and the found-ID list in RAM.
// Depends on sips_pkg and sips_ram.
`default_nettype none

module sips_ctrl #(
  parameter int unsigned MAX_IDS = 28
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  output logic                item_ready_o,
  input  wire sips_pkg::item_t item_i,
  input  wire sips_pkg::cfg_t  cfg_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output sips_pkg::res_t      res_o
);

  import sips_pkg::*;

  localparam int unsigned IW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int unsigned CW = $clog2(MAX_IDS + 1);

  state_e state_q, state_d;
  item_t  item_q;

  logic [CW-1:0]       found_cnt_q, found_cnt_d;
  logic [CW-1:0]       query_idx_q, query_idx_d;
  logic [CW-1:0]       srch_q, srch_d;
  logic [IW-1:0]       scan_cur_q, scan_cur_d;
  logic                scan_phase_q, scan_phase_d;
  logic [31:0]         next_poll_q, next_poll_d;
  logic [31:0]         disc_end_q, disc_end_d;
  logic [WIN_US_W-1:0] win_us_q;
  logic [PERIOD_W-1:0] period_q;
  logic [7:0]          tx_byte_q, tx_byte_d;
  logic [7:0]          tx_prim_q, tx_prim_d;
  logic                rx_valid_q, rx_valid_d;
  logic [4:0]          rx_id_q, rx_id_d;

  logic                ram_we, ram_re;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [4:0]          ram_rdata;

  logic [PERIOD_W-1:0] period_clamp;
  logic [WIN_MS_W-1:0] win_ms_clamp;
  logic [31:0]         diff_poll, diff_end;
  logic                poll_early, win_expired;
  logic [CW-1:0]       qidx_base, qidx_eff;
  logic [4:0]          reply_id;

  sips_ram #(
    .WIDTH (5),
    .DEPTH (MAX_IDS)
  ) u_found_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (item_q.rx_id_byte[4:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    period_clamp = cfg_i.poll_period_us;
    if (period_clamp < PERIOD_MIN) period_clamp = PERIOD_MIN;
    if (period_clamp > PERIOD_MAX) period_clamp = PERIOD_MAX;
    win_ms_clamp = cfg_i.discovery_time_ms;
    if (win_ms_clamp < WIN_MS_MIN) win_ms_clamp = WIN_MS_MIN;
    if (win_ms_clamp > WIN_MS_MAX) win_ms_clamp = WIN_MS_MAX;
  end

  // wrapping time compare: a is before b when bit 31 of a - b is set
  assign diff_poll   = item_q.now_us - next_poll_q;
  assign diff_end    = item_q.now_us - disc_end_q;
  assign poll_early  = diff_poll[31];
  assign win_expired = scan_phase_q && !diff_end[31];
  assign qidx_base   = win_expired ? '0 : query_idx_q;
  assign qidx_eff    = (qidx_base >= found_cnt_q) ? '0 : qidx_base;
  assign reply_id    = item_q.rx_id_byte[4:0] & ID_MASK;

  always_comb begin
    state_d      = state_q;
    found_cnt_d  = found_cnt_q;
    query_idx_d  = query_idx_q;
    srch_d       = srch_q;
    scan_cur_d   = scan_cur_q;
    scan_phase_d = scan_phase_q;
    next_poll_d  = next_poll_q;
    disc_end_d   = disc_end_q;
    tx_byte_d    = tx_byte_q;
    tx_prim_d    = tx_prim_q;
    rx_valid_d   = rx_valid_q;
    rx_id_d      = rx_id_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = found_cnt_q[IW-1:0];
    ram_raddr    = srch_q[IW-1:0];
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) state_d = ST_PREP;
      end

      ST_PREP: state_d = ST_EXEC;

      ST_EXEC: begin
        tx_byte_d  = '0;
        tx_prim_d  = PRIM_NULL;
        rx_valid_d = 1'b0;
        rx_id_d    = '0;
        state_d    = ST_DONE;
        case (item_q.op)
          OP_POLL: begin
            if (!poll_early) begin
              next_poll_d = item_q.now_us + 32'(period_q);
              if (win_expired) begin
                scan_phase_d = 1'b0;
                query_idx_d  = '0;
              end
              if (scan_phase_q && !win_expired) begin
                scan_cur_d = (scan_cur_q == IW'(MAX_IDS - 1)) ? '0 : scan_cur_q + 1'b1;
                tx_byte_d  = add_check_bits(5'(scan_cur_q));
                tx_prim_d  = PRIM_DATA;
              end else if (found_cnt_q == '0) begin
                // nothing found: reopen the discovery window
                scan_phase_d = 1'b1;
                scan_cur_d   = '0;
                disc_end_d   = item_q.now_us + 32'(win_us_q);
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = qidx_eff[IW-1:0];
                query_idx_d = qidx_eff + 1'b1;
                state_d     = ST_READ;
              end
            end
          end
          OP_REPLY: begin
            if (add_check_bits(reply_id) == item_q.rx_id_byte) begin
              rx_valid_d = 1'b1;
              rx_id_d    = reply_id;
              if (scan_phase_q) begin
                if (found_cnt_q == '0) begin
                  ram_we      = 1'b1;
                  found_cnt_d = found_cnt_q + 1'b1;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  srch_d    = CW'(1);
                  state_d   = ST_SRCH;
                end
              end
            end
          end
          OP_RESTART: begin
            found_cnt_d  = '0;
            query_idx_d  = '0;
            scan_cur_d   = '0;
            scan_phase_d = 1'b1;
            disc_end_d   = item_q.now_us + 32'(win_us_q);
          end
          default: ;
        endcase
      end

      ST_READ: begin
        tx_byte_d = add_check_bits(ram_rdata);
        tx_prim_d = PRIM_DATA;
        state_d   = ST_DONE;
      end

      // ram_rdata holds entry srch_q-1
      ST_SRCH: begin
        if (ram_rdata == reply_id) begin
          state_d = ST_DONE;
        end else if (srch_q == found_cnt_q) begin
          if (found_cnt_q < CW'(MAX_IDS)) begin
            ram_we      = 1'b1;
            found_cnt_d = found_cnt_q + 1'b1;
          end
          state_d = ST_DONE;
        end else begin
          ram_re = 1'b1;
          srch_d = srch_q + 1'b1;
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      found_cnt_q  <= '0;
      query_idx_q  <= '0;
      scan_cur_q   <= '0;
      scan_phase_q <= 1'b1;
      next_poll_q  <= '0;
      disc_end_q   <= '0;
    end else begin
      state_q      <= state_d;
      found_cnt_q  <= found_cnt_d;
      query_idx_q  <= query_idx_d;
      scan_cur_q   <= scan_cur_d;
      scan_phase_q <= scan_phase_d;
      next_poll_q  <= next_poll_d;
      disc_end_q   <= disc_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) item_q <= item_i;
    if (state_q == ST_PREP) begin
      win_us_q <= WIN_US_W'(win_ms_clamp * 26'(US_PER_MS));
      period_q <= period_clamp;
    end
    srch_q     <= srch_d;
    tx_byte_q  <= tx_byte_d;
    tx_prim_q  <= tx_prim_d;
    rx_valid_q <= rx_valid_d;
    rx_id_q    <= rx_id_d;
  end

  assign res_o.tx_id_byte  = tx_byte_q;
  assign res_o.tx_prim     = tx_prim_q;
  assign res_o.rx_id_valid = rx_valid_q;
  assign res_o.rx_id       = rx_id_q;
  assign res_o.ids_found   = 5'(found_cnt_q);
  assign res_o.scanning    = scan_phase_q;

endmodule

`default_nettype wire

/* design/sensor_id_poll_scheduler_top.sv */
// Top level of the sensor ID poll scheduler: stream ports, APB registers, output register.
// Depends on sips_pkg, sips_ctrl (and through it sips_ram).
//
//  Channel   Dir   Handshake               Payload
//  s_axis    in    s_axis_tvalid/tready    tuser op; tdata now_us, rx_id_byte
//  m_axis    out   m_axis_tvalid/tready    tuser rx_id_valid; tdata result fields
//  apb       in    psel/penable/pready     poll_period_us @0x0, discovery_time_ms @0x4
//
// One word at a time: a poll or restart passes through PREP, EXEC and DONE before the
// next word can be accepted, a poll served from the found list also through READ, and
// a valid reply during discovery with IDs found through SRCH, where the list RAM is
// searched one entry per cycle until a match or the end of the list. The output
// register frees the core while it waits. Reset is asynchronous; the list RAM needs
// no clearing, only entries below the found count are read. A stalled m_axis holds
// the core once one result is queued.
`default_nettype none

module sensor_id_poll_scheduler_top #(
  parameter int unsigned MAX_IDS = 28
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [31:0] now_us, [39:32] rx_id_byte
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] op
  // stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [7:0] tx_id_byte, [15:8] tx_prim,
                                          // [20:16] rx_id, [25:21] ids_found,
                                          // [26] scanning, [31:27] zero
  output logic [0:0]       m_axis_tuser,  // [0] rx_id_valid
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import sips_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  res_t  res, out_q;
  logic  res_valid, res_ready, out_valid_q;
  logic  reg_wr;

  // registers
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_period_us    <= PERIOD_RESET;
      cfg_q.discovery_time_ms <= WIN_MS_RESET;
    end else if (reg_wr) begin
      if (paddr[2] == REG_PERIOD) cfg_q.poll_period_us <= pwdata[PERIOD_W-1:0];
      else cfg_q.discovery_time_ms <= pwdata[WIN_MS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW) ? 32'(cfg_q.discovery_time_ms)
                                           : 32'(cfg_q.poll_period_us);

  assign item.op         = s_axis_tuser;
  assign item.now_us     = s_axis_tdata[31:0];
  assign item.rx_id_byte = s_axis_tdata[39:32];

  sips_ctrl #(
    .MAX_IDS (MAX_IDS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.scanning, out_q.ids_found, out_q.rx_id,
                          out_q.tx_prim, out_q.tx_id_byte};
  assign m_axis_tuser  = out_q.rx_id_valid;

  // core stays busy for the word it just took
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !res_valid)
    else $error("core accepted a word while still busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (MAX_IDS >= 32) || (6'(res.ids_found) <= 6'(MAX_IDS)))
    else $error("found count exceeds list depth");

  a_tx_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res.tx_prim == PRIM_NULL && res.tx_id_byte == 8'd0) ||
                  (res.tx_prim == PRIM_DATA &&
                   add_check_bits(res.tx_id_byte[4:0]) == res.tx_id_byte))
    else $error("malformed transmit frame");

  a_rx_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res.rx_id_valid |-> res.rx_id == 5'd0)
    else $error("rx_id set without a valid reply");

endmodule

`default_nettype wire
